/* rtl/tmwf_pkg.sv */
// tmwf_pkg: shared widths, reset values and the controller/datapath link types
// of the trimmed mean window filter; no dependencies
`timescale 1ns / 1ps

package tmwf_pkg;

    localparam int MEASURE_W  = 16;
    localparam int BURST_W    = 20;
    localparam int SPM_W      = 5;
    localparam int IDX_W      = 4;
    localparam int FILL_OUT_W = 4;

    localparam logic [SPM_W-1:0] SPM_RESET = 5'd10;
    localparam logic [SPM_W-1:0] SPM_MIN   = 5'd1;
    localparam logic [SPM_W-1:0] SPM_MAX   = 5'd16;

    // fill / 3 as (fill * 43) >> 7, exact for fill below 128
    localparam int TRIM_MUL   = 43;
    localparam int TRIM_SHIFT = 7;

    typedef struct packed {
        logic accept;
        logic avg_start;
        logic push;
        logic sort_load;
        logic sort_step;
        logic sum_step;
        logic mean_start;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic burst_done;
        logic div_done;
        logic cnt_last;
    } dp_status_t;

endpackage

/* rtl/tmwf_if.sv */
// tmwf_in_if / tmwf_out_if: valid/ready channels carrying one input word
// and one result word; uses tmwf_pkg for field widths
`timescale 1ns / 1ps

interface tmwf_in_if;
    logic                           valid;
    logic                           ready;
    logic [tmwf_pkg::MEASURE_W-1:0] raw_count;

    modport source (output valid, output raw_count, input ready);
    modport sink   (input valid, input raw_count, output ready);
endinterface

interface tmwf_out_if;
    logic                            valid;
    logic                            ready;
    logic [tmwf_pkg::MEASURE_W-1:0]  new_measure;
    logic [tmwf_pkg::MEASURE_W-1:0]  filtered;
    logic [tmwf_pkg::FILL_OUT_W-1:0] window_fill;

    modport source (output valid, output new_measure, output filtered, output window_fill,
                    input ready);
    modport sink   (input valid, input new_measure, input filtered, input window_fill,
                    output ready);
endinterface

/* rtl/tmwf_div.sv */
// tmwf_div: restoring divider, one quotient bit per cycle
// standalone, used by tmwf_datapath for both the burst average and the mean
`timescale 1ns / 1ps

module tmwf_div #(
    parameter int DIV_W = 20,
    parameter int DVS_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   rem_shift;
    logic [DVS_W:0]   diff;
    logic             fits;

    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};
    assign fits      = ~diff[DVS_W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

/* rtl/tmwf_ctrl.sv */
// tmwf_ctrl: sequencer of the filter; drives datapath commands and the
// channel handshakes; uses tmwf_pkg for the command and status types
`timescale 1ns / 1ps

module tmwf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tmwf_pkg::dp_cmd_t    cmd,
    input  tmwf_pkg::dp_status_t st
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_AVG    = 8'b0000_0010,
        S_LOAD   = 8'b0000_0100,
        S_SORT   = 8'b0000_1000,
        S_SUM    = 8'b0001_0000,
        S_MSTART = 8'b0010_0000,
        S_MEAN   = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (st.burst_done)
                    begin
                        cmd.avg_start = 1'b1;
                        state_next    = S_AVG;
                    end
                end
            end
            S_AVG:
            begin
                if (st.div_done)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.sort_load = 1'b1;
                state_next    = S_SORT;
            end
            S_SORT:
            begin
                cmd.sort_step = 1'b1;
                if (st.cnt_last)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (st.cnt_last)
                begin
                    state_next = S_MSTART;
                end
            end
            S_MSTART:
            begin
                cmd.mean_start = 1'b1;
                state_next     = S_MEAN;
            end
            S_MEAN:
            begin
                if (st.div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // wait until the output register is free or being drained
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/tmwf_datapath.sv */
// tmwf_datapath: burst accumulator, window store, odd-even sort row, trimmed
// sum and output register; uses tmwf_pkg and instantiates tmwf_div
`timescale 1ns / 1ps

module tmwf_datapath #(
    parameter int WINDOW_DEPTH = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tmwf_pkg::dp_cmd_t                 cmd,
    output tmwf_pkg::dp_status_t              st,
    input  logic                              cfg_we,
    input  logic [tmwf_pkg::SPM_W-1:0]        cfg_wdata,
    input  logic [tmwf_pkg::MEASURE_W-1:0]    raw_count,
    output logic [tmwf_pkg::MEASURE_W-1:0]    new_measure,
    output logic [tmwf_pkg::MEASURE_W-1:0]    filtered,
    output logic [tmwf_pkg::FILL_OUT_W-1:0]   window_fill
);

    localparam int MW      = tmwf_pkg::MEASURE_W;
    localparam int BW      = tmwf_pkg::BURST_W;
    localparam int SW      = tmwf_pkg::SPM_W;
    localparam int IW      = tmwf_pkg::IDX_W;
    localparam int FILL_OUT_W_L = tmwf_pkg::FILL_OUT_W;
    localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SLOT_W  = $clog2(WINDOW_DEPTH);
    localparam int CNT_W   = $clog2(WINDOW_DEPTH);
    localparam int SUM_W   = MW + FILL_W;
    localparam int DIV_W   = (SUM_W > BW) ? SUM_W : BW;
    localparam int DVS_W   = (FILL_W > SW) ? FILL_W : SW;
    localparam int KEY_W   = MW + 1;
    localparam int PROD_W  = FILL_W + 6;

    // burst accumulation
    logic [SW-1:0]   spm_reg;
    logic [SW-1:0]   spm_eff;
    logic [BW-1:0]   total_reg;
    logic [BW-1:0]   total_sum;
    logic [IW-1:0]   idx_reg;
    logic [IW:0]     idx_plus;

    // window
    logic [MW-1:0]     win_reg [WINDOW_DEPTH];
    logic [FILL_W-1:0] fill_reg;
    logic [SLOT_W-1:0] oldest_reg;
    logic [SLOT_W-1:0] wr_slot;
    logic              full;

    // sort and trimmed sum
    logic [KEY_W-1:0]  sort_reg  [WINDOW_DEPTH];
    logic [KEY_W-1:0]  sort_next [WINDOW_DEPTH];
    logic [CNT_W-1:0]  cnt_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [PROD_W-1:0] trim_prod;
    logic [FILL_W-1:0] drop;
    logic [FILL_W-1:0] hi;
    logic [FILL_W-1:0] keep;
    logic [FILL_W-1:0] cnt_ext;
    logic              in_band;

    // shared divider
    logic [DIV_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic [DIV_W-1:0] div_quo;
    logic             div_done;
    logic [MW-1:0]    measure_sat;

    logic [MW-1:0]          measure_reg;
    logic [MW-1:0]          new_measure_reg;
    logic [MW-1:0]          filtered_reg;
    logic [FILL_OUT_W_L-1:0] fill_out_reg;

    always_comb
    begin
        if (spm_reg < tmwf_pkg::SPM_MIN)
        begin
            spm_eff = tmwf_pkg::SPM_MIN;
        end
        else if (spm_reg > tmwf_pkg::SPM_MAX)
        begin
            spm_eff = tmwf_pkg::SPM_MAX;
        end
        else
        begin
            spm_eff = spm_reg;
        end
    end

    assign total_sum = total_reg + BW'(raw_count);
    assign idx_plus  = {1'b0, idx_reg} + 1'b1;

    assign st.burst_done = (idx_plus >= spm_eff);
    assign st.div_done   = div_done;
    assign st.cnt_last   = (cnt_reg == CNT_W'(WINDOW_DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spm_reg   <= tmwf_pkg::SPM_RESET;
            total_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                spm_reg <= cfg_wdata;
            end
            if (cmd.accept)
            begin
                if (st.burst_done)
                begin
                    total_reg <= '0;
                    idx_reg   <= '0;
                end
                else
                begin
                    total_reg <= total_sum;
                    idx_reg   <= idx_plus[IW-1:0];
                end
            end
        end
    end

    // average saturates to the measure range
    assign measure_sat = (|div_quo[DIV_W-1:MW]) ? {MW{1'b1}} : div_quo[MW-1:0];

    assign full    = (fill_reg == FILL_W'(WINDOW_DEPTH));
    assign wr_slot = full ? oldest_reg : fill_reg[SLOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            oldest_reg <= '0;
        end
        else if (cmd.push)
        begin
            if (full)
            begin
                oldest_reg <= (oldest_reg == SLOT_W'(WINDOW_DEPTH - 1)) ? '0
                                                                        : oldest_reg + 1'b1;
            end
            else
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            win_reg[wr_slot] <= measure_sat;
            measure_reg      <= measure_sat;
        end
    end

    // sort row: key msb marks an empty slot so it sorts to the top end;
    // odd-even transposition passes, then shifted down one entry per cycle
    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_cell
        localparam logic ODD = ((i % 2) == 1);
        logic [KEY_W-1:0] up_key;
        logic [KEY_W-1:0] dn_key;

        if (i + 1 < WINDOW_DEPTH)
        begin : g_up
            assign up_key = sort_reg[i+1];
        end
        else
        begin : g_top
            assign up_key = '1;
        end

        if (i > 0)
        begin : g_dn
            assign dn_key = sort_reg[i-1];
        end
        else
        begin : g_bot
            assign dn_key = '0;
        end

        always_comb
        begin
            sort_next[i] = sort_reg[i];
            if (cmd.sort_load)
            begin
                sort_next[i] = (FILL_W'(i) >= fill_reg) ? {1'b1, {MW{1'b0}}}
                                                        : {1'b0, win_reg[i]};
            end
            else if (cmd.sort_step)
            begin
                if (ODD == cnt_reg[0])
                begin
                    sort_next[i] = (sort_reg[i] > up_key) ? up_key : sort_reg[i];
                end
                else
                begin
                    sort_next[i] = (dn_key > sort_reg[i]) ? dn_key : sort_reg[i];
                end
            end
            else if (cmd.sum_step)
            begin
                sort_next[i] = up_key;
            end
        end

        always_ff @(posedge clk)
        begin
            sort_reg[i] <= sort_next[i];
        end
    end

    assign trim_prod = PROD_W'(fill_reg) * PROD_W'(tmwf_pkg::TRIM_MUL);
    assign drop      = FILL_W'(trim_prod >> tmwf_pkg::TRIM_SHIFT);
    assign hi        = fill_reg - drop;
    assign keep      = hi - drop;
    assign cnt_ext   = FILL_W'(cnt_reg);
    assign in_band   = (cnt_ext >= drop) && (cnt_ext < hi);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.sort_load)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.sort_step || cmd.sum_step)
        begin
            cnt_reg <= st.cnt_last ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sort_load)
        begin
            sum_reg <= '0;
        end
        else if (cmd.sum_step && in_band)
        begin
            sum_reg <= sum_reg + SUM_W'(sort_reg[0][MW-1:0]);
        end
    end

    assign div_dividend = cmd.avg_start ? DIV_W'(total_sum) : DIV_W'(sum_reg);
    assign div_divisor  = cmd.avg_start ? DVS_W'(spm_eff) : DVS_W'(keep);

    tmwf_div #(
        .DIV_W (DIV_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.avg_start | cmd.mean_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .done     (div_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            new_measure_reg <= measure_reg;
            filtered_reg    <= div_quo[MW-1:0];
            fill_out_reg    <= FILL_OUT_W_L'(fill_reg);
        end
    end

    assign new_measure = new_measure_reg;
    assign filtered    = filtered_reg;
    assign window_fill = fill_out_reg;

endmodule

/* rtl/trimmed_mean_window_filter.sv */
// trimmed_mean_window_filter: top level of the trimmed mean window filter
// uses tmwf_pkg, tmwf_in_if / tmwf_out_if, tmwf_ctrl and tmwf_datapath
`timescale 1ns / 1ps

// usage
// - in_ch carries one raw_count word per handshake (valid and ready high at a
//   rising edge); out_ch carries new_measure, filtered and window_fill
// - cfg_we / cfg_wdata write samples_per_measure (reset 10); write it only
//   while the block is idle
// - a word that does not complete a burst keeps in_ch ready; the next word
//   can follow right away
// - the word that completes a burst shows its result on out_ch after the
//   burst average in the one-bit-per-cycle divider, the window push, the
//   sort load, the WINDOW_DEPTH sort passes, WINDOW_DEPTH summing steps and
//   the mean in the same divider
// - the result sits in an output register; in_ch is ready again as soon as
//   the result is loaded, even while out_ch is stalled
// - a stalled out_ch holds the next finished result back inside the block,
//   and in_ch stays not ready until the output register frees up
// - reset clears the burst, empties the window and drops any pending result
module trimmed_mean_window_filter #(
    parameter int WINDOW_DEPTH = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    tmwf_in_if.sink                    in_ch,
    tmwf_out_if.source                 out_ch,
    input  logic                       cfg_we,
    input  logic [tmwf_pkg::SPM_W-1:0] cfg_wdata
);

    tmwf_pkg::dp_cmd_t    cmd;
    tmwf_pkg::dp_status_t st;

    tmwf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .st        (st)
    );

    tmwf_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .raw_count   (in_ch.raw_count),
        .new_measure (out_ch.new_measure),
        .filtered    (out_ch.filtered),
        .window_fill (out_ch.window_fill)
    );

endmodule

/* rtl/tmwf_checker.sv */
// tmwf_checker: port-level assertions on the trimmed mean window filter,
// bound to the top level; uses tmwf_pkg for field widths
`timescale 1ns / 1ps

module tmwf_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [tmwf_pkg::MEASURE_W-1:0]  new_measure,
    input logic [tmwf_pkg::MEASURE_W-1:0]  filtered,
    input logic [tmwf_pkg::FILL_OUT_W-1:0] window_fill
);

    // a stalled result word keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_measure)
            && $stable(filtered) && $stable(window_fill))
        else $error("result word changed while stalled");

    // the block only goes busy after taking a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("input went not ready without an accepted word");

    // a new result is only loaded at the end of a busy stretch
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a preceding computation");

endmodule

bind trimmed_mean_window_filter tmwf_checker u_tmwf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .new_measure (out_ch.new_measure),
    .filtered    (out_ch.filtered),
    .window_fill (out_ch.window_fill)
);
